// File: sv/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

  // normalized magnitudes keep their top bit here
  localparam int NORM_MSB   = 29;
  localparam int NORM_BITS  = NORM_MSB + 1;
  // sum of three squared normalized magnitudes, and its root
  localparam int SQR_BITS   = 2 * NORM_BITS + 2;
  localparam int ROOT_BITS  = NORM_BITS + 1;
  // leading-one search works on groups of this many bits
  localparam int GROUP      = 8;
  // register stages of the normalizer ahead of the square root
  localparam int NORM_FRONT = 6;

  // front stages, root steps, divider set-up and steps, output register
  function automatic int norm_latency(input int frac_bits);
    return NORM_FRONT + ROOT_BITS + (frac_bits + 2) + 2;
  endfunction

endpackage

// File: sv/lavm_delay.sv
// ----------------------------------------------------------------------------
// lavm_delay
// Payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module lavm_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (ce) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// File: sv/lavm_isqrt.sv
// ----------------------------------------------------------------------------
// lavm_isqrt
// Floor square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module lavm_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [lavm_pkg::SQR_BITS-1:0] radicand,
  output logic                          out_valid,
  output logic [lavm_pkg::ROOT_BITS-1:0] root
);
  import lavm_pkg::*;

  logic [SQR_BITS-1:0] xs      [ROOT_BITS];
  logic [SQR_BITS-1:0] rs      [ROOT_BITS];
  logic                vs      [ROOT_BITS];
  logic [SQR_BITS-1:0] xs_next [ROOT_BITS];
  logic [SQR_BITS-1:0] rs_next [ROOT_BITS];

  always_comb begin
    logic [SQR_BITS-1:0] x_in;
    logic [SQR_BITS-1:0] r_in;
    logic [SQR_BITS-1:0] bitv;
    logic [SQR_BITS-1:0] t;
    for (int k = 0; k < ROOT_BITS; k++) begin
      x_in = (k == 0) ? radicand : xs[(k == 0) ? 0 : k-1];
      r_in = (k == 0) ? '0 : rs[(k == 0) ? 0 : k-1];
      bitv = SQR_BITS'(1) << (2 * (ROOT_BITS - 1 - k));
      t = r_in + bitv;
      if (x_in >= t) begin
        xs_next[k] = x_in - t;
        rs_next[k] = (r_in >> 1) + bitv;
      end else begin
        xs_next[k] = x_in;
        rs_next[k] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < ROOT_BITS; k++) begin
        xs[k] <= xs_next[k];
        rs[k] <= rs_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_BITS; k++) vs[k] <= 1'b0;
    end else if (ce) begin
      vs[0] <= in_valid;
      for (int k = 1; k < ROOT_BITS; k++) vs[k] <= vs[k-1];
    end
  end

  assign out_valid = vs[ROOT_BITS-1];
  assign root      = rs[ROOT_BITS-1][ROOT_BITS-1:0];

endmodule

// File: sv/lavm_udiv.sv
// ----------------------------------------------------------------------------
// lavm_udiv
// Three-lane rounded divide of scaled magnitudes by a shared length,
// one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module lavm_udiv #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 ce,
  input  logic                                 in_valid,
  input  logic [2:0][lavm_pkg::NORM_BITS-1:0]  mag,
  input  logic [lavm_pkg::ROOT_BITS-1:0]       den,
  output logic                                 out_valid,
  output logic [2:0][FRAC_BITS+1:0]            quo
);
  import lavm_pkg::*;

  localparam int QB   = FRAC_BITS + 2;
  localparam int NUMW = NORM_BITS + FRAC_BITS + 1;
  localparam int RW   = ROOT_BITS + 1;

  logic [2:0][RW-1:0]     rs      [QB+1];
  logic [2:0][QB-1:0]     lq      [QB+1];
  logic [ROOT_BITS-1:0]   ds      [QB+1];
  logic                   vs      [QB+1];
  logic [2:0][RW-1:0]     rs_next [QB+1];
  logic [2:0][QB-1:0]     lq_next [QB+1];

  // stage 0 adds half the length; the quotient is known to fit QB bits, so
  // the bits above them already sit below the divisor
  always_comb begin
    logic [NUMW-1:0] num;
    logic [RW-1:0]   cat;
    logic            ge;
    for (int i = 0; i < 3; i++) begin
      num = (NUMW'(mag[i]) << FRAC_BITS) + NUMW'(den >> 1);
      rs_next[0][i] = RW'(num >> QB);
      lq_next[0][i] = num[QB-1:0];
    end
    for (int j = 1; j <= QB; j++) begin
      for (int i = 0; i < 3; i++) begin
        cat = {rs[j-1][i][RW-2:0], lq[j-1][i][QB-1]};
        ge  = (cat >= RW'(ds[j-1]));
        rs_next[j][i] = ge ? (cat - RW'(ds[j-1])) : cat;
        lq_next[j][i] = {lq[j-1][i][QB-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ds[0] <= den;
      for (int j = 0; j <= QB; j++) begin
        rs[j] <= rs_next[j];
        lq[j] <= lq_next[j];
      end
      for (int j = 1; j <= QB; j++) ds[j] <= ds[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QB; j++) vs[j] <= 1'b0;
    end else if (ce) begin
      vs[0] <= in_valid;
      for (int j = 1; j <= QB; j++) vs[j] <= vs[j-1];
    end
  end

  assign out_valid = vs[QB];
  assign quo       = lq[QB];

endmodule

// File: sv/lavm_norm.sv
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined vector normalizer: block shift of the magnitudes, squares,
// square root, rounded divide, sign and saturation.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int W           = 25,
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [2:0][W-1:0]            vec,
  output logic                         out_valid,
  output logic [2:0][COORD_WIDTH-1:0]  unit
);
  import lavm_pkg::*;

  localparam int NG  = (W + GROUP - 1) / GROUP;
  localparam int PW  = $clog2(W);
  localparam int GW  = $clog2(GROUP);
  localparam int XW  = W + NORM_MSB;
  localparam int SQW = 2 * NORM_BITS;
  localparam int QB  = FRAC_BITS + 2;
  localparam int EW  = ((QB > COORD_WIDTH) ? QB : COORD_WIDTH) + 2;
  localparam longint CMAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam logic signed [EW-1:0] UMAX = EW'(CMAX);
  localparam logic signed [EW-1:0] UMIN = EW'(-CMAX - 1);

  logic                      v1, v2, v3, v4, v5, v6;
  logic [2:0][W-1:0]         m1, m2, m3;
  logic [2:0]                s1, s2, s3, s4, s5, s6;
  logic                      z3, z4, z5, z6;
  logic [NG-1:0]             nz2;
  logic [GW-1:0]             gp2 [NG];
  logic [PW-1:0]             p3;
  logic [2:0][NORM_BITS-1:0] sh4, sh5, sh6;
  logic [SQW-1:0]            sq5 [3];
  logic [SQR_BITS-1:0]       sum6;

  logic [NG-1:0]             nz_c;
  logic [GW-1:0]             gp_c [NG];
  logic [PW-1:0]             p_c;
  logic [2:0][NORM_BITS-1:0] sh_c;

  // per-group leading one of the or of all magnitudes
  always_comb begin
    logic [NG*GROUP-1:0] all;
    logic [GROUP-1:0]    chunk;
    all = (NG*GROUP)'(m1[0] | m1[1] | m1[2]);
    for (int g = 0; g < NG; g++) begin
      chunk   = all[g*GROUP +: GROUP];
      nz_c[g] = |chunk;
      gp_c[g] = '0;
      for (int b = 0; b < GROUP; b++) begin
        if (chunk[b]) gp_c[g] = GW'(b);
      end
    end
  end

  always_comb begin
    p_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (nz2[g]) p_c = PW'(g * GROUP + int'(gp2[g]));
    end
  end

  // one right shift covers both directions: top bit lands on NORM_MSB
  always_comb begin
    logic [XW-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext     = {m3[i], {NORM_MSB{1'b0}}} >> p3;
      sh_c[i] = ext[NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= vec[i][W-1];
        m1[i] <= vec[i][W-1] ? W'(~vec[i] + 1'b1) : vec[i];
      end
      m2 <= m1;
      s2 <= s1;
      nz2 <= nz_c;
      for (int g = 0; g < NG; g++) gp2[g] <= gp_c[g];
      m3 <= m2;
      s3 <= s2;
      z3 <= ~|nz2;
      p3 <= p_c;
      sh4 <= sh_c;
      s4 <= s3;
      z4 <= z3;
      for (int i = 0; i < 3; i++) sq5[i] <= sh4[i] * sh4[i];
      sh5 <= sh4;
      s5 <= s4;
      z5 <= z4;
      sum6 <= SQR_BITS'(sq5[0]) + SQR_BITS'(sq5[1]) + SQR_BITS'(sq5[2]);
      sh6 <= sh5;
      s6 <= s5;
      z6 <= z5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  logic                      root_valid;
  logic [ROOT_BITS-1:0]      root;
  logic [2:0][NORM_BITS-1:0] sh_a;
  logic [2:0]                s_a, s_b;
  logic                      z_a, z_b;
  logic                      q_valid;
  logic [2:0][QB-1:0]        quo;

  lavm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v6),
    .radicand  (sum6),
    .out_valid (root_valid),
    .root      (root)
  );

  lavm_delay #(.WIDTH(3 * NORM_BITS + 4), .DEPTH(ROOT_BITS)) u_side_root (
    .clk (clk),
    .ce  (ce),
    .d   ({z6, s6, sh6}),
    .q   ({z_a, s_a, sh_a})
  );

  lavm_udiv #(.FRAC_BITS(FRAC_BITS)) u_udiv (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (root_valid),
    .mag       (sh_a),
    .den       (root),
    .out_valid (q_valid),
    .quo       (quo)
  );

  lavm_delay #(.WIDTH(4), .DEPTH(QB + 1)) u_side_div (
    .clk (clk),
    .ce  (ce),
    .d   ({z_a, s_a}),
    .q   ({z_b, s_b})
  );

  logic [2:0][COORD_WIDTH-1:0] unit_c;

  always_comb begin
    logic signed [EW-1:0] val;
    for (int i = 0; i < 3; i++) begin
      val = $signed(EW'(quo[i]));
      if (s_b[i]) val = -val;
      if (z_b) begin
        unit_c[i] = '0;
      end else if (val > UMAX) begin
        unit_c[i] = COORD_WIDTH'(UMAX);
      end else if (val < UMIN) begin
        unit_c[i] = COORD_WIDTH'(UMIN);
      end else begin
        unit_c[i] = COORD_WIDTH'(val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) unit <= unit_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= q_valid;
    end
  end

endmodule

// File: sv/lavm_cross.sv
// ----------------------------------------------------------------------------
// lavm_cross
// Exact signed cross product: products in one stage, differences in the next.
// ----------------------------------------------------------------------------
module lavm_cross #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic [2:0][AW-1:0]       a,
  input  logic [2:0][BW-1:0]       b,
  output logic                     out_valid,
  output logic [2:0][AW+BW:0]      r
);

  logic signed [AW+BW-1:0] prod [6];
  logic                    pv;

  always_ff @(posedge clk) begin
    if (ce) begin
      prod[0] <= $signed(a[1]) * $signed(b[2]);
      prod[1] <= $signed(a[2]) * $signed(b[1]);
      prod[2] <= $signed(a[2]) * $signed(b[0]);
      prod[3] <= $signed(a[0]) * $signed(b[2]);
      prod[4] <= $signed(a[0]) * $signed(b[1]);
      prod[5] <= $signed(a[1]) * $signed(b[0]);
      r[0] <= (AW+BW+1)'(prod[0]) - (AW+BW+1)'(prod[1]);
      r[1] <= (AW+BW+1)'(prod[2]) - (AW+BW+1)'(prod[3]);
      r[2] <= (AW+BW+1)'(prod[4]) - (AW+BW+1)'(prod[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      pv        <= in_valid;
      out_valid <= pv;
    end
  end

endmodule

// File: sv/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view basis and translation from camera position, target and up hint.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   pos xyz, target xyz, hint_up xyz
//  m_*      out  m_tvalid/m_tready   right xyz, true_up xyz, dir xyz, trans xyz
//
//  One camera enters per cycle while s_tready is high, that is while the
//  output skid slot is free. The two normalizers produce one root bit and
//  one quotient bit per stage. Reset clears only the valid bits. A stalled output holds the
//  whole pipeline once its two-entry output buffer is full; nothing is dropped.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // pos_x, pos_y, pos_z, target_x, target_y, target_z,
  // hint_up_x, hint_up_y, hint_up_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // right_x, right_y, right_z, true_up_x, true_up_y, true_up_z,
  // dir_x, dir_y, dir_z, trans_x, trans_y, trans_z
  output logic [((12*COORD_WIDTH+7)/8)*8-1:0]        m_tdata
);
  import lavm_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int OUT_W = 12 * CW;
  localparam int OTW   = ((12 * CW + 7) / 8) * 8;
  localparam int NL    = norm_latency(FRAC_BITS);
  localparam int SW    = 2 * CW + 2;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
  localparam logic signed [SW:0] TMAX = (SW+1)'(CMAX);
  localparam logic signed [SW:0] TMIN = (SW+1)'(-CMAX - 1);

  // round half away from zero, optional negate, saturate
  function automatic logic [CW-1:0] round_sat(input logic signed [SW-1:0] v,
                                              input logic neg);
    logic [SW-1:0]     mag;
    logic signed [SW:0] r;
    mag = v[SW-1] ? SW'(~v + 1'b1) : SW'(v);
    mag = (mag + HALF) >> FRAC_BITS;
    r = $signed({1'b0, mag});
    if (v[SW-1] ^ neg) r = -r;
    if (r > TMAX) return CW'(TMAX);
    if (r < TMIN) return CW'(TMIN);
    return CW'(r);
  endfunction

  logic ce;

  // input stage
  logic                 v1;
  logic [2:0][CW-1:0]   pos1, hint1;
  logic [2:0][CW:0]     diff1;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        pos1[i]  <= s_tdata[CW*i +: CW];
        hint1[i] <= s_tdata[CW*(6+i) +: CW];
        diff1[i] <= (CW+1)'($signed(s_tdata[CW*i +: CW]))
                  - (CW+1)'($signed(s_tdata[CW*(3+i) +: CW]));
      end
    end
  end

  logic               vd, vc, vr, vu;
  logic [2:0][CW-1:0] dir, pos_a, hint_a, dir_b, pos_b, dir_c, pos_c;
  logic [2:0][CW-1:0] right, right_d, dir_d, pos_d;
  logic [2:0][2*CW:0] rc, upraw;

  lavm_norm #(.W(CW + 1), .COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_norm_dir (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v1),
    .vec       (diff1),
    .out_valid (vd),
    .unit      (dir)
  );

  lavm_delay #(.WIDTH(6 * CW), .DEPTH(NL)) u_dly_a (
    .clk (clk),
    .ce  (ce),
    .d   ({hint1, pos1}),
    .q   ({hint_a, pos_a})
  );

  lavm_cross #(.AW(CW), .BW(CW)) u_cross_right (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (vd),
    .a         (hint_a),
    .b         (dir),
    .out_valid (vc),
    .r         (rc)
  );

  lavm_delay #(.WIDTH(6 * CW), .DEPTH(2)) u_dly_b (
    .clk (clk),
    .ce  (ce),
    .d   ({dir, pos_a}),
    .q   ({dir_b, pos_b})
  );

  lavm_norm #(.W(2 * CW + 1), .COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (vc),
    .vec       (rc),
    .out_valid (vr),
    .unit      (right)
  );

  lavm_delay #(.WIDTH(6 * CW), .DEPTH(NL)) u_dly_c (
    .clk (clk),
    .ce  (ce),
    .d   ({dir_b, pos_b}),
    .q   ({dir_c, pos_c})
  );

  lavm_cross #(.AW(CW), .BW(CW)) u_cross_up (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (vr),
    .a         (dir_c),
    .b         (right),
    .out_valid (vu),
    .r         (upraw)
  );

  lavm_delay #(.WIDTH(9 * CW), .DEPTH(2)) u_dly_d (
    .clk (clk),
    .ce  (ce),
    .d   ({right, dir_c, pos_c}),
    .q   ({right_d, dir_d, pos_d})
  );

  // true up rounding, dot products, translation
  logic                    v_r, v_p, v_s, v_f;
  logic [2:0][CW-1:0]      up_r, right_r, dir_r, pos_r;
  logic [2:0][CW-1:0]      up_p, right_p, dir_p;
  logic [2:0][CW-1:0]      up_s, right_s, dir_s;
  logic [2:0][CW-1:0]      up_f, right_f, dir_f, trans_f;
  logic signed [2*CW-1:0]  prod_p [3][3];
  logic signed [SW-1:0]    sum_s  [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        up_r[i] <= round_sat(SW'($signed(upraw[i])), 1'b0);
      end
      right_r <= right_d;
      dir_r   <= dir_d;
      pos_r   <= pos_d;

      for (int i = 0; i < 3; i++) begin
        prod_p[0][i] <= $signed(right_r[i]) * $signed(pos_r[i]);
        prod_p[1][i] <= $signed(up_r[i]) * $signed(pos_r[i]);
        prod_p[2][i] <= $signed(dir_r[i]) * $signed(pos_r[i]);
      end
      up_p    <= up_r;
      right_p <= right_r;
      dir_p   <= dir_r;

      for (int k = 0; k < 3; k++) begin
        sum_s[k] <= SW'(prod_p[k][0]) + SW'(prod_p[k][1]) + SW'(prod_p[k][2]);
      end
      up_s    <= up_p;
      right_s <= right_p;
      dir_s   <= dir_p;

      for (int k = 0; k < 3; k++) trans_f[k] <= round_sat(sum_s[k], 1'b1);
      up_f    <= up_s;
      right_f <= right_s;
      dir_f   <= dir_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v_r <= 1'b0;
      v_p <= 1'b0;
      v_s <= 1'b0;
      v_f <= 1'b0;
    end else if (ce) begin
      v1  <= s_tvalid;
      v_r <= vu;
      v_p <= v_r;
      v_s <= v_p;
      v_f <= v_s;
    end
  end

  // output register plus skid slot; the pipeline runs while the slot is free
  logic [OUT_W-1:0] fin;
  logic [OTW-1:0]   sk_data;
  logic             sk_valid;

  assign fin      = {trans_f, dir_f, up_f, right_f};
  assign ce       = ~sk_valid;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!sk_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= v_f;
      end else if (v_f) begin
        sk_valid <= 1'b1;
      end
    end else if (m_tready) begin
      sk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= OTW'(fin);
      end else begin
        sk_data <= OTW'(fin);
      end
    end else if (m_tready) begin
      m_tdata <= sk_data;
    end
  end

endmodule

// File: tb/tb_look_at_view_matrix.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// Drives cameras into the look-at pipeline under several idle/stall patterns
// and checks every output transfer against a fixed-point basis calculator.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;
  import lavm_pkg::*;

  localparam int CW      = 24;
  localparam int FB      = 16;
  localparam int IN_W    = ((9 * CW + 7) / 8) * 8;
  localparam int OUT_W   = ((12 * CW + 7) / 8) * 8;
  localparam int LAT     = 2 * FB + 91;
  localparam int WD_MAX  = 20000;
  localparam int N_RAND  = 600;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE  = CW'(1) << FB;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t v[12];
  } basis_t;
  typedef struct {
    coord_t c[9];
    bit     known;
    basis_t res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;

  look_at_view_matrix #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  basis_t expected_bases[$];
  int     errors = 0;
  int     cams_sent = 0;
  int     bases_seen = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     wd_count = 0;
  bit     timed_out = 0;

  function automatic longint sat_coord(longint v);
    if (v > longint'(CMAX)) return longint'(CMAX);
    if (v < longint'(CMIN)) return longint'(CMIN);
    return v;
  endfunction

  function automatic longint round_frac(longint v);
    longint unsigned u;
    u = (v < 0) ? -v : v;
    u = (u + (64'd1 << (FB - 1))) >> FB;
    return (v < 0) ? -longint'(u) : longint'(u);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale-free unit vector, zero stays zero
  function automatic void unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      u[i] = sat_coord((v[i] < 0) ? -longint'(q) : longint'(q));
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint neg_dot_sat(longint b[3], longint p[3]);
    return sat_coord(-round_frac(b[0] * p[0] + b[1] * p[1] + b[2] * p[2]));
  endfunction

  function automatic basis_t view_basis(coord_t c[9]);
    longint pos[3], hint[3], diff[3], dir[3], rc[3], right[3], upr[3], up[3];
    basis_t b;
    for (int i = 0; i < 3; i++) begin
      pos[i]  = c[i];
      hint[i] = c[6 + i];
      diff[i] = longint'(c[i]) - longint'(c[3 + i]);
    end
    unit_vec(diff, dir);
    cross3(hint, dir, rc);
    unit_vec(rc, right);
    cross3(dir, right, upr);
    for (int i = 0; i < 3; i++) up[i] = sat_coord(round_frac(upr[i]));
    for (int i = 0; i < 3; i++) begin
      b.v[i]     = coord_t'(right[i]);
      b.v[3 + i] = coord_t'(up[i]);
      b.v[6 + i] = coord_t'(dir[i]);
    end
    b.v[9]  = coord_t'(neg_dot_sat(right, pos));
    b.v[10] = coord_t'(neg_dot_sat(up, pos));
    b.v[11] = coord_t'(neg_dot_sat(dir, pos));
    return b;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at output %0d: %s", bases_seen, what);
    errors++;
  endtask

  // valid stays high between back-to-back cameras; it drops only while idling
  task automatic send_camera(input coord_t c[9], input bit known, input basis_t res);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CW +: CW] = c[i];
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tdata  <= d;
    s_tvalid <= 1;
    expected_bases.push_back(known ? res : view_basis(c));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cams_sent++;
    @(negedge clk);
  endtask

  // output side: random stall, check each transfer
  always @(negedge clk) begin
    if (!rst) m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bases.size() == 0) begin
        report_mismatch("output with no camera pending");
      end else begin
        basis_t e;
        e = expected_bases.pop_front();
        for (int i = 0; i < 12; i++)
          if (coord_t'(m_tdata[i*CW +: CW]) !== e.v[i])
            report_mismatch($sformatf("field %0d got %0d want %0d", i,
                                      coord_t'(m_tdata[i*CW +: CW]), e.v[i]));
      end
      bases_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      wd_count <= 0;
    end else if (wd_count >= WD_MAX) begin
      timed_out <= 1;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return coord_t'(coord_t'($urandom_range(0, 2 * ONE)) - ONE);
      2: return ($urandom_range(1)) ? CMAX : CMIN;
      default: return coord_t'(coord_t'($urandom_range(0, 40 * ONE)) - 20 * ONE);
    endcase
  endfunction

  row_t directed[$];

  function automatic row_t mk(coord_t c[9]);
    row_t r;
    r.c = c;
    r.known = 0;
    return r;
  endfunction

  task automatic build_directed();
    row_t r;
    // camera on its target: whole basis is zero
    r = mk('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
    r.known = 1;
    foreach (r.res.v[i]) r.res.v[i] = 0;
    directed.push_back(r);
    r = mk('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    r.known = 1;
    foreach (r.res.v[i]) r.res.v[i] = 0;
    directed.push_back(r);
    // canonical camera at +z looking at origin, up = y
    r = mk('{0, 0, ONE, 0, 0, 0, 0, ONE, 0});
    r.known = 1;
    r.res.v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, -ONE};
    directed.push_back(r);
    // up hint parallel to dir: right and true up vanish
    directed.push_back(mk('{0, 5 * ONE, 0, 0, 0, 0, 0, ONE, 0}));
    directed.push_back(mk('{0, 0, 0, 0, 0, 0, 0, ONE, 0}));
    directed.push_back(mk('{ONE, 0, 0, 0, 0, 0, 0, 0, 0}));
    // extremes, translation saturation
    directed.push_back(mk('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN}));
    directed.push_back(mk('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX}));
    directed.push_back(mk('{CMAX, 0, CMIN, CMIN, 0, CMAX, 0, CMAX, 0}));
    directed.push_back(mk('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX - 1, 1, 0, 0}));
    directed.push_back(mk('{1, 0, 0, 0, 0, 0, 0, 0, 1}));
    directed.push_back(mk('{-1, -1, -1, 0, 0, 0, -1, 1, -1}));
    directed.push_back(mk('{CMIN, CMAX, 1, -1, CMIN, CMAX, CMAX, CMAX, CMAX}));
    directed.push_back(mk('{24'h555555, 24'h2aaaaa, 24'h555555, 24'h2aaaaa, 24'h555555,
                            24'h2aaaaa, 24'h555555, 24'h2aaaaa, 24'h555555}));
    directed.push_back(mk('{24'haaaaaa, 24'hd55555, 24'haaaaaa, 24'hd55555, 24'haaaaaa,
                            24'hd55555, 24'haaaaaa, 24'hd55555, 24'haaaaaa}));
  endtask

  initial begin
    coord_t c[9];
    basis_t none;
    int i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    build_directed();
    foreach (directed[k]) send_camera(directed[k].c, directed[k].known, directed[k].res);
    for (i = 0; i < N_RAND; i++) begin
      case (i / (N_RAND / 4))
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      // bursts with no idling inside each phase
      if ((i % 50) < 8) begin idle_pct = 0; stall_pct = 0; end
      foreach (c[j]) c[j] = rand_coord();
      if ($urandom_range(19) == 0) for (int j = 0; j < 3; j++) c[3 + j] = c[j];
      if ($urandom_range(19) == 0) begin
        c[6] = c[0] - c[3]; c[7] = c[1] - c[4]; c[8] = c[2] - c[5];
      end
      send_camera(c, 0, none);
    end
    s_tvalid <= 0;
    stall_pct = 10;
    while (expected_bases.size() != 0 && !timed_out) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (timed_out) begin
      $display("FAILURE");
    end else begin
      $display("sent %0d cameras (directed edge cases and random), checked %0d outputs",
               cams_sent, bases_seen);
      $display("under idle, stall and burst patterns; %0d mismatches", errors);
      if (errors == 0 && expected_bases.size() == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("FAILURE");
      $finish;
    end
  end
endmodule

// File: sim.f
sv/lavm_pkg.sv
sv/lavm_delay.sv
sv/lavm_isqrt.sv
sv/lavm_udiv.sv
sv/lavm_norm.sv
sv/lavm_cross.sv
sv/look_at_view_matrix.sv
tb/tb_look_at_view_matrix.sv
